/* rtl/cnpa_pkg.sv */
// Shared types, constants and the CRC step function for the nonce page assembler.
package cnpa_pkg;

    // Default sizing of the nonce store and pages
    localparam int NONCE_BYTES_DEF      = 256;
    localparam int PAGE_BYTES_DEF       = 56;
    localparam int NONCE_PAGE_COUNT_DEF = 5;

    // Report framing
    localparam logic [6:0] REPORT_LEN    = 7'd63;
    localparam logic [6:0] CRC_COVER     = 7'd59;
    localparam logic [6:0] PAYLOAD_OFF   = 7'd3;
    localparam int         STAGE_DEPTH   = 56;
    localparam int         LAST_PAGE_LEN = 32;

    // Copy counter and offset arithmetic widths
    localparam int CNT_W = 6;
    localparam int OFF_W = 16;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [7:0]  SEED_RESET = 8'hF0;

    // Configuration register indexes
    localparam int         CFG_IDX_W   = 1;
    localparam logic [0:0] REG_ENABLED = 1'd0;
    localparam logic [0:0] REG_SEED    = 1'd1;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_CRC  = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_ID       = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;
    localparam logic [2:0] ST_DISABLED = 3'd5;
    localparam logic [2:0] ST_READ     = 3'd6;

    // Nonce phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_RECV     = 2'd1;
    localparam logic [1:0] PH_COMPLETE = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       end_of_report;
        logic [7:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_data;
        logic [7:0] report_page;
        logic [7:0] current_id;
        logic [1:0] phase;
        logic       nonce_complete;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic byte_en;
        logic rd_en;
        logic eval_en;
        logic clr_en;
        logic copy_en;
        logic load_read;
        logic load_report;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_needed;
        logic copy_needed;
        logic clr_last;
        logic copy_done;
    } stat_t;

    function automatic logic [31:0] crc_fold(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

/* rtl/cnpa_ctrl.sv */
// Controller state machine: sequences byte intake, reads, checks, clear sweep, copy and result.
module cnpa_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_op,
    input  logic           in_eor,
    output logic           out_valid,
    input  logic           out_ready,
    input  cnpa_pkg::stat_t stat,
    output cnpa_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_BOOT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_CLEAR  = 3'd4;
    localparam logic [2:0] S_COPY   = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.byte_en = accept && !in_op;
        cmd.rd_en   = accept && in_op;
        state_next  = state_reg;
        case (state_reg)
            S_BOOT:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op)
                    begin
                        state_next = S_RDWAIT;
                    end
                    else if (in_eor)
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_RDWAIT:
            begin
                if (slot_free)
                begin
                    cmd.load_read = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EVAL:
            begin
                cmd.eval_en = 1'b1;
                if (stat.clear_needed)
                begin
                    state_next = S_CLEAR;
                end
                else if (stat.copy_needed)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                cmd.copy_en = 1'b1;
                if (stat.copy_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    cmd.load_report = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until the transfer completes; a new load replaces it
    always_comb
    begin
        if (cmd.load_read || cmd.load_report)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_BOOT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/cnpa_dp.sv */
// Datapath: CRC, report header and staging memory, checks, nonce store and result register.
module cnpa_dp
#(
    parameter int NONCE_BYTES      = cnpa_pkg::NONCE_BYTES_DEF,
    parameter int PAGE_BYTES       = cnpa_pkg::PAGE_BYTES_DEF,
    parameter int NONCE_PAGE_COUNT = cnpa_pkg::NONCE_PAGE_COUNT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cnpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  cnpa_pkg::in_item_t             in_data,
    input  cnpa_pkg::cmd_t                 cmd,
    output cnpa_pkg::stat_t                stat,
    output cnpa_pkg::out_item_t            out_data
);

    localparam int ADDR_W = $clog2(NONCE_BYTES);
    localparam int CNT_W  = cnpa_pkg::CNT_W;
    localparam int OFF_W  = cnpa_pkg::OFF_W;

    // Configuration
    logic        enabled_reg;
    logic [31:0] seed_crc_reg;

    // Report intake
    logic [6:0]  pos_reg;
    logic [31:0] crc_reg;
    logic [31:0] rcv_crc_reg;
    logic [7:0]  hdr_id_reg;
    logic [7:0]  hdr_page_reg;
    logic        short_reg;

    // Nonce state
    logic [7:0]  latched_id_reg;
    logic [1:0]  phase_reg;
    logic [2:0]  status_reg;
    logic        done_reg;

    // Copy and clear sequencing
    logic [ADDR_W-1:0] offset_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  cp_cnt_reg;
    logic [CNT_W-1:0]  cp_idx_reg;
    logic              cp_vld_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // Memory read data
    logic [7:0] rd_q_reg;
    logic       rd_oob_reg;
    logic [7:0] stage_q_reg;

    cnpa_pkg::out_item_t out_reg;

    logic [7:0] staging_mem [0:cnpa_pkg::STAGE_DEPTH-1];
    logic [7:0] nonce_mem   [0:NONCE_BYTES-1];

    // Byte intake next values
    logic        in_frame;
    logic [31:0] crc_base;
    logic [31:0] crc_next;
    logic [31:0] rcv_base;
    logic [31:0] rcv_next;
    logic [1:0]  crc_lane;
    logic [7:0]  hdr_id_next;
    logic [7:0]  hdr_page_next;
    logic [6:0]  pos_adv;
    logic        stage_we;
    logic [5:0]  stage_waddr;

    // Checks
    logic        crc_ok;
    logic        page_ok;
    logic        page_zero;
    logic        page_last;
    logic        id_ok;
    logic [2:0]  chk_code;
    logic        pass;
    logic [OFF_W-1:0] off_full;
    logic [OFF_W-1:0] len_raw;
    logic [OFF_W-1:0] len_clip;
    logic [OFF_W-1:0] nb_ext;

    // Store port
    logic              cp_rd;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_oob;

    assign in_frame    = pos_reg < cnpa_pkg::REPORT_LEN;
    assign crc_base    = (pos_reg == 7'd0) ? seed_crc_reg : crc_reg;
    assign crc_next    = (pos_reg < cnpa_pkg::CRC_COVER)
                         ? cnpa_pkg::crc_fold(crc_base, in_data.data_byte) : crc_base;
    assign rcv_base    = (pos_reg == 7'd0) ? 32'd0 : rcv_crc_reg;
    assign crc_lane    = 2'(pos_reg - cnpa_pkg::CRC_COVER);
    assign rcv_next    = (in_frame && pos_reg >= cnpa_pkg::CRC_COVER)
                         ? (rcv_base | ({24'd0, in_data.data_byte} << {crc_lane, 3'b000}))
                         : rcv_base;
    assign hdr_id_next = (pos_reg == 7'd0) ? in_data.data_byte : hdr_id_reg;
    assign pos_adv     = in_frame ? (pos_reg + 7'd1) : pos_reg;

    always_comb
    begin
        if (pos_reg == 7'd0)
        begin
            hdr_page_next = 8'd0;
        end
        else if (pos_reg == 7'd1)
        begin
            hdr_page_next = in_data.data_byte;
        end
        else
        begin
            hdr_page_next = hdr_page_reg;
        end
    end

    assign stage_we    = cmd.byte_en && pos_reg >= cnpa_pkg::PAYLOAD_OFF
                         && pos_reg < cnpa_pkg::CRC_COVER;
    assign stage_waddr = 6'(pos_reg - cnpa_pkg::PAYLOAD_OFF);

    // Report checks, in priority order
    assign crc_ok    = (crc_reg ^ cnpa_pkg::CRC_INIT) == rcv_crc_reg;
    assign page_ok   = hdr_page_reg < 8'(NONCE_PAGE_COUNT);
    assign page_zero = hdr_page_reg == 8'd0;
    assign page_last = hdr_page_reg == 8'(NONCE_PAGE_COUNT - 1);
    assign id_ok     = hdr_id_reg == latched_id_reg;

    always_comb
    begin
        if (!enabled_reg)
        begin
            chk_code = cnpa_pkg::ST_DISABLED;
        end
        else if (short_reg)
        begin
            chk_code = cnpa_pkg::ST_SHORT;
        end
        else if (!page_ok)
        begin
            chk_code = cnpa_pkg::ST_RANGE;
        end
        else if (!crc_ok)
        begin
            chk_code = cnpa_pkg::ST_BAD_CRC;
        end
        else if (!page_zero && !id_ok)
        begin
            chk_code = cnpa_pkg::ST_ID;
        end
        else
        begin
            chk_code = cnpa_pkg::ST_OK;
        end
    end

    assign pass = (chk_code == cnpa_pkg::ST_OK);

    // Page offset and copy length, clipped to the store
    assign off_full = OFF_W'(hdr_page_reg) * OFF_W'(PAGE_BYTES);
    assign len_raw  = page_last ? OFF_W'(cnpa_pkg::LAST_PAGE_LEN) : OFF_W'(PAGE_BYTES);
    assign nb_ext   = OFF_W'(NONCE_BYTES);

    always_comb
    begin
        if (off_full >= nb_ext)
        begin
            len_clip = '0;
        end
        else if (off_full + len_raw > nb_ext)
        begin
            len_clip = nb_ext - off_full;
        end
        else
        begin
            len_clip = len_raw;
        end
    end

    assign cp_rd = cmd.copy_en && (cp_cnt_reg < len_reg);

    assign stat.clear_needed = pass && page_zero;
    assign stat.copy_needed  = pass;
    assign stat.clr_last     = clr_cnt_reg == ADDR_W'(NONCE_BYTES - 1);
    assign stat.copy_done    = !cp_rd && !cp_vld_reg;

    // Single write port of the store: clear sweep or page copy
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = 8'd0;
        if (cmd.clr_en)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.copy_en && cp_vld_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = offset_reg + ADDR_W'(cp_idx_reg);
            mem_wdata = stage_q_reg;
        end
    end

    assign rd_addr = ADDR_W'(in_data.read_index);
    assign rd_oob  = 32'(in_data.read_index) >= NONCE_BYTES;

    always_ff @(posedge clk)
    begin
        if (stage_we)
        begin
            staging_mem[stage_waddr] <= in_data.data_byte;
        end
        if (cp_rd)
        begin
            stage_q_reg <= staging_mem[cp_cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            nonce_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_q_reg   <= nonce_mem[rd_addr];
            rd_oob_reg <= rd_oob;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.byte_en)
        begin
            crc_reg      <= crc_next;
            rcv_crc_reg  <= rcv_next;
            hdr_id_reg   <= hdr_id_next;
            hdr_page_reg <= hdr_page_next;
            short_reg    <= pos_adv < cnpa_pkg::REPORT_LEN;
        end
        if (cmd.eval_en)
        begin
            status_reg <= chk_code;
            done_reg   <= pass && page_last;
            offset_reg <= ADDR_W'(off_full);
            len_reg    <= CNT_W'(len_clip);
            cp_idx_reg <= '0;
        end
        else if (cmd.copy_en)
        begin
            cp_idx_reg <= cp_cnt_reg;
        end
        if (cmd.load_read)
        begin
            out_reg.status         <= cnpa_pkg::ST_READ;
            out_reg.read_data      <= rd_oob_reg ? 8'd0 : rd_q_reg;
            out_reg.report_page    <= 8'd0;
            out_reg.current_id     <= latched_id_reg;
            out_reg.phase          <= phase_reg;
            out_reg.nonce_complete <= 1'b0;
        end
        else if (cmd.load_report)
        begin
            out_reg.status         <= status_reg;
            out_reg.read_data      <= 8'd0;
            out_reg.report_page    <= hdr_page_reg;
            out_reg.current_id     <= latched_id_reg;
            out_reg.phase          <= phase_reg;
            out_reg.nonce_complete <= done_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            seed_crc_reg   <= cnpa_pkg::crc_fold(cnpa_pkg::CRC_INIT, cnpa_pkg::SEED_RESET);
            pos_reg        <= 7'd0;
            latched_id_reg <= 8'd0;
            phase_reg      <= cnpa_pkg::PH_IDLE;
            cp_cnt_reg     <= '0;
            cp_vld_reg     <= 1'b0;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cnpa_pkg::REG_ENABLED: enabled_reg <= cfg_data[0];
                    cnpa_pkg::REG_SEED:
                        seed_crc_reg <= cnpa_pkg::crc_fold(cnpa_pkg::CRC_INIT, cfg_data);
                    default: ;
                endcase
            end
            if (cmd.byte_en)
            begin
                pos_reg <= in_data.end_of_report ? 7'd0 : pos_adv;
            end
            if (cmd.eval_en)
            begin
                cp_cnt_reg <= '0;
                cp_vld_reg <= 1'b0;
                if (pass && page_zero)
                begin
                    latched_id_reg <= hdr_id_reg;
                    phase_reg      <= cnpa_pkg::PH_RECV;
                end
                // Last page overrides, also when it is page zero
                if (pass && page_last)
                begin
                    phase_reg <= cnpa_pkg::PH_COMPLETE;
                end
            end
            else if (cmd.copy_en)
            begin
                cp_cnt_reg <= cp_cnt_reg + CNT_W'(cp_rd);
                cp_vld_reg <= cp_rd;
            end
            if (cmd.clr_en)
            begin
                clr_cnt_reg <= stat.clr_last ? '0 : clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    assign out_data = out_reg;

endmodule

/* rtl/crc_checked_nonce_page_assembler.sv */
// Top level of the CRC-checked nonce page assembler: controller, datapath and checks.
//
//  channel | signals                          | moves
//  --------+----------------------------------+-----------------------------------------
//  in      | in_valid, in_ready, in_data      | report byte or nonce read request
//  out     | out_valid, out_ready, out_data   | report verdict or nonce read reply
//  cfg     | cfg_we, cfg_index, cfg_data      | register write, no wait
//
// A report byte without end mark keeps the input ready. A read registers the store byte,
// then loads its reply into the output register once it is free. A report end runs the checks,
// a clear sweep of the store on a good page zero, then on a good page the copy through the
// one write port of the nonce store (filling the staging read register, then seeing the
// pipeline empty), then the result. A clearing pass after reset precedes the first transfer.
// A result waiting in the output register does not block bytes; the next result waits for it.
module crc_checked_nonce_page_assembler
#(
    parameter int NONCE_BYTES      = cnpa_pkg::NONCE_BYTES_DEF,
    parameter int PAGE_BYTES       = cnpa_pkg::PAGE_BYTES_DEF,
    parameter int NONCE_PAGE_COUNT = cnpa_pkg::NONCE_PAGE_COUNT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cnpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cnpa_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cnpa_pkg::out_item_t            out_data
);

    cnpa_pkg::cmd_t  cmd;
    cnpa_pkg::stat_t stat;

    cnpa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (in_data.op),
        .in_eor    (in_data.end_of_report),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cnpa_dp
    #(
        .NONCE_BYTES      (NONCE_BYTES),
        .PAGE_BYTES       (PAGE_BYTES),
        .NONCE_PAGE_COUNT (NONCE_PAGE_COUNT)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.byte_en | cmd.rd_en, cmd.eval_en, cmd.clr_en, cmd.copy_en}))
        else $error("more than one datapath command active");

    a_no_sweep_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.clr_en && !cmd.copy_en)
        else $error("store sweep or copy while accepting input");

    a_complete_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.nonce_complete
        |-> out_data.status == cnpa_pkg::ST_OK && out_data.phase == cnpa_pkg::PH_COMPLETE)
        else $error("nonce complete flagged without accepted last page");

    a_read_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == cnpa_pkg::ST_READ
        |-> out_data.report_page == 8'd0 && !out_data.nonce_complete)
        else $error("read reply carries report fields");
`endif

endmodule
